@@ sv/sbp_pkg.sv @@
// Package with types, constants and the output remap for the six-button pad read sequencer.
`default_nettype none
package sbp_pkg;

	localparam int READ_CYCLES = 8;
	localparam int IDX_W = 3;
	localparam int CYC_W = IDX_W + 1;

	localparam logic [CYC_W-1:0] CYC_PRESENCE = CYC_W'(2);
	localparam logic [CYC_W-1:0] CYC_DPAD     = CYC_W'(3);
	localparam logic [CYC_W-1:0] CYC_DETECT   = CYC_W'(4);
	localparam logic [CYC_W-1:0] CYC_EXTRA    = CYC_W'(5);
	localparam logic [CYC_W-1:0] CYC_LAST     = CYC_W'(READ_CYCLES);

	localparam int B_UP    = 0;
	localparam int B_DOWN  = 1;
	localparam int B_LEFT  = 2;
	localparam int B_RIGHT = 3;
	localparam int B_A     = 4;
	localparam int B_B     = 5;
	localparam int B_C     = 6;
	localparam int B_START = 7;
	localparam int B_X     = 8;
	localparam int B_Y     = 9;
	localparam int B_Z     = 10;
	localparam int B_MODE  = 11;

	localparam logic [11:0] ALL_RELEASED = 12'hFFF;
	localparam logic [11:0] XYZM_MASK    = 12'hF00;

	typedef struct packed {
		logic up;
		logic down;
		logic left;
		logic right;
		logic six;
		logic nine;
	} pins_t;

	typedef struct packed {
		logic [IDX_W-1:0] cycle_index;
		logic [11:0]      pad_buttons;
		logic             six_mode;
		logic [11:0]      held_outputs;
	} seq_state_t;

	typedef struct packed {
		logic        select_next;
		logic [11:0] console_buttons;
		logic        six_button_mode;
		logic        read_done;
	} result_t;

	function automatic logic [11:0] remap(input logic [11:0] pad, input logic six_mode);
		logic [11:0] o;
		o[0] = pad[B_C];
		o[1] = pad[B_B];
		o[2] = pad[B_LEFT];
		o[3] = pad[B_RIGHT];
		o[4] = pad[B_START];
		o[5] = pad[B_UP];
		o[6] = pad[B_DOWN];
		if (six_mode) begin
			o[7]  = pad[B_MODE];
			o[8]  = pad[B_A];
			o[9]  = pad[B_X];
			o[10] = pad[B_Y];
			o[11] = pad[B_Z];
		end else begin
			o[7]    = pad[B_A];
			o[11:8] = 4'hF;
		end
		return o;
	endfunction

endpackage
`default_nettype wire

@@ sv/sbp_step.sv @@
// Next-state and result logic for one sampled cycle of the pad read.
`default_nettype none
module sbp_step (
	input  wire sbp_pkg::seq_state_t cur,
	input  wire sbp_pkg::pins_t      pins,
	output sbp_pkg::seq_state_t      nxt,
	output sbp_pkg::result_t         res
);
	import sbp_pkg::*;

	logic [CYC_W-1:0] cyc;
	logic             done;

	always_comb begin
		cyc  = {1'b0, cur.cycle_index} + CYC_W'(1);
		nxt  = cur;
		done = 1'b0;
		case (cyc)
			CYC_PRESENCE: begin
				if (!(pins.left | pins.right)) begin
					nxt.pad_buttons[B_A]     = pins.six;
					nxt.pad_buttons[B_START] = pins.nine;
				end else begin
					nxt.pad_buttons = ALL_RELEASED;
					nxt.six_mode    = 1'b0;
					done            = 1'b1;
				end
			end
			CYC_DPAD: begin
				nxt.pad_buttons[B_UP]    = pins.up;
				nxt.pad_buttons[B_DOWN]  = pins.down;
				nxt.pad_buttons[B_LEFT]  = pins.left;
				nxt.pad_buttons[B_RIGHT] = pins.right;
				nxt.pad_buttons[B_B]     = pins.six;
				nxt.pad_buttons[B_C]     = pins.nine;
			end
			CYC_DETECT: begin
				nxt.six_mode = !pins.up && !pins.down;
			end
			CYC_EXTRA: begin
				if (cur.six_mode) begin
					nxt.pad_buttons[B_Z]    = pins.up;
					nxt.pad_buttons[B_Y]    = pins.down;
					nxt.pad_buttons[B_X]    = pins.left;
					nxt.pad_buttons[B_MODE] = pins.right;
				end else begin
					nxt.pad_buttons = cur.pad_buttons | XYZM_MASK;
				end
			end
			default: begin
			end
		endcase
		if (cyc >= CYC_LAST) begin
			done = 1'b1;
		end
		if (done) begin
			nxt.held_outputs = remap(nxt.pad_buttons, nxt.six_mode);
			nxt.cycle_index  = '0;
		end else begin
			nxt.cycle_index = cyc[IDX_W-1:0];
		end
		res.select_next     = ~nxt.cycle_index[0];
		res.console_buttons = nxt.held_outputs;
		res.six_button_mode = nxt.six_mode;
		res.read_done       = done;
	end

endmodule
`default_nettype wire

@@ sv/six_button_pad_read_sequencer.sv @@
// Top level of the six-button pad read sequencer.
// Each input word is one sampled cycle of a multiplexed pad read:
// the six active-low pad pins taken under the select level driven last.
// Each accepted input word yields exactly one output word carrying the select
// level for the next cycle, the twelve held console button outputs, the
// six-button mode flag and a flag that marks the end of a read.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. The output word appears in the cycle after its input word is accepted.
// Throughput is one word per cycle while the output is not stalled: the sequencer
// state and the output register update together at each accepted input word.
// While the receiver stalls a waiting output word, the output holds steady and
// the input is stalled until that word has been taken.
// Reset starts a read at its first cycle with all buttons released and
// six-button mode cleared; no output word is pending after reset.
`default_nettype none
module six_button_pad_read_sequencer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         pin_up,
	input  wire         pin_down,
	input  wire         pin_left,
	input  wire         pin_right,
	input  wire         pin_six,
	input  wire         pin_nine,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        select_next,
	output logic [11:0] console_buttons,
	output logic        six_button_mode,
	output logic        read_done
);
	import sbp_pkg::*;

	seq_state_t state_q;
	seq_state_t state_nxt;
	pins_t      pins;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;
	logic       accept;

	assign pins = '{up: pin_up, down: pin_down, left: pin_left, right: pin_right,
		six: pin_six, nine: pin_nine};

	sbp_step u_step (
		.cur  (state_q),
		.pins (pins),
		.nxt  (state_nxt),
		.res  (res)
	);

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cycle_index  <= '0;
			state_q.pad_buttons  <= ALL_RELEASED;
			state_q.six_mode     <= 1'b0;
			state_q.held_outputs <= ALL_RELEASED;
			out_valid_q          <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign select_next     = res_q.select_next;
	assign console_buttons = res_q.console_buttons;
	assign six_button_mode = res_q.six_button_mode;
	assign read_done       = res_q.read_done;

endmodule
`default_nettype wire
